@@ hdl/kva_pkg.sv @@
// Package for the keyboard voice allocator: transfer structs, sequencer states,
// key code constants, the note pitch ROM and key decode helpers.
// No dependencies.
package kva_pkg;

    localparam int VOICES_DEFAULT = 4;

    // Input event codes
    localparam logic [15:0] EV_KEY      = 16'd1;
    localparam logic [1:0]  REQ_RELEASE = 2'd0;
    localparam logic [1:0]  REQ_PRESS   = 2'd1;

    // Control keys
    localparam logic [9:0] KEY_ESC         = 10'd1;
    localparam logic [9:0] KEY_VOL_DOWN    = 10'd12;
    localparam logic [9:0] KEY_VOL_UP      = 10'd13;
    localparam logic [9:0] KEY_FILTER      = 10'd57;
    localparam logic [9:0] KEY_KP7         = 10'd71;
    localparam logic [9:0] KEY_KP8         = 10'd72;
    localparam logic [9:0] KEY_KP9         = 10'd73;
    localparam logic [9:0] KEY_CUTOFF_DOWN = 10'd74;
    localparam logic [9:0] KEY_KP4         = 10'd75;
    localparam logic [9:0] KEY_KP5         = 10'd76;
    localparam logic [9:0] KEY_KP6         = 10'd77;
    localparam logic [9:0] KEY_CUTOFF_UP   = 10'd78;
    localparam logic [9:0] KEY_KP1         = 10'd79;
    localparam logic [9:0] KEY_KP2         = 10'd80;
    localparam logic [9:0] KEY_KP3         = 10'd81;
    localparam logic [9:0] KEY_NONE        = 10'd0;

    // Settings limits and reset values
    localparam logic [12:0] CUTOFF_MAX   = 13'd5000;
    localparam logic [12:0] CUTOFF_STEP  = 13'd100;
    localparam logic [12:0] CUTOFF_RESET = 13'd1000;
    localparam logic [4:0]  VOLUME_MAX   = 5'd20;
    localparam logic [4:0]  VOLUME_RESET = 5'd10;
    localparam logic [3:0]  OCTAVE_RESET = 4'd4;

    localparam int PITCH_ROM_SIZE = 118;

    // round(440 * 2^((n-48)/12))
    localparam logic [14:0] PITCH_ROM [PITCH_ROM_SIZE] = '{
        15'd28,    15'd29,    15'd31,    15'd33,    15'd35,    15'd37,
        15'd39,    15'd41,    15'd44,    15'd46,    15'd49,    15'd52,
        15'd55,    15'd58,    15'd62,    15'd65,    15'd69,    15'd73,
        15'd78,    15'd82,    15'd87,    15'd92,    15'd98,    15'd104,
        15'd110,   15'd117,   15'd123,   15'd131,   15'd139,   15'd147,
        15'd156,   15'd165,   15'd175,   15'd185,   15'd196,   15'd208,
        15'd220,   15'd233,   15'd247,   15'd262,   15'd277,   15'd294,
        15'd311,   15'd330,   15'd349,   15'd370,   15'd392,   15'd415,
        15'd440,   15'd466,   15'd494,   15'd523,   15'd554,   15'd587,
        15'd622,   15'd659,   15'd698,   15'd740,   15'd784,   15'd831,
        15'd880,   15'd932,   15'd988,   15'd1047,  15'd1109,  15'd1175,
        15'd1245,  15'd1319,  15'd1397,  15'd1480,  15'd1568,  15'd1661,
        15'd1760,  15'd1865,  15'd1976,  15'd2093,  15'd2217,  15'd2349,
        15'd2489,  15'd2637,  15'd2794,  15'd2960,  15'd3136,  15'd3322,
        15'd3520,  15'd3729,  15'd3951,  15'd4186,  15'd4435,  15'd4699,
        15'd4978,  15'd5274,  15'd5588,  15'd5920,  15'd6272,  15'd6645,
        15'd7040,  15'd7459,  15'd7902,  15'd8372,  15'd8870,  15'd9397,
        15'd9956,  15'd10548, 15'd11175, 15'd11840, 15'd12544, 15'd13290,
        15'd14080, 15'd14917, 15'd15804, 15'd16744, 15'd17740, 15'd18795,
        15'd19912, 15'd21096, 15'd22351, 15'd23680
    };

    typedef struct packed {
        logic [15:0] event_kind;
        logic [9:0]  key_code;
        logic [1:0]  req_type;
    } kva_cmd_t;

    typedef struct packed {
        logic        voice_updated;
        logic [1:0]  voice_index;
        logic [14:0] voice_pitch;
        logic        voice_on;
        logic [1:0]  voice_waveform;
        logic [12:0] filter_cutoff;
        logic        filter_enabled;
        logic [4:0]  volume_steps;
        logic [3:0]  octave_now;
        logic        exit_request;
    } kva_rsp_t;

    typedef struct packed {
        logic        updated;
        logic [1:0]  index;
        logic [14:0] pitch;
        logic        on;
        logic [1:0]  waveform;
    } kva_voice_t;

    typedef struct packed {
        logic [12:0] cutoff;
        logic        filter;
        logic [4:0]  volume;
        logic [3:0]  octave;
        logic        exit_flag;
    } kva_settings_t;

    typedef struct packed {
        logic       en;
        logic [9:0] key;
        logic [1:0] wave;
    } kva_slot_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } kva_state_t;

    function automatic logic is_note_key(input logic [9:0] code);
        logic hit;
        hit = code inside {[10'd2:10'd8], [10'd16:10'd22], [10'd30:10'd36], [10'd44:10'd50]};
        return hit;
    endfunction

    // (code+1) mod 14 for note keys
    function automatic logic [3:0] note_offset(input logic [9:0] code);
        logic [9:0] v;
        v = code + 10'd1;
        if (code inside {[10'd44:10'd50]})
            v = code - 10'd41;
        else if (code inside {[10'd30:10'd36]})
            v = code - 10'd27;
        else if (code inside {[10'd16:10'd22]})
            v = code - 10'd13;
        return v[3:0];
    endfunction

    // (code+1) / 14 for note keys: the key row
    function automatic logic [1:0] note_wave(input logic [9:0] code);
        logic [1:0] w;
        w = 2'd0;
        if (code inside {[10'd44:10'd50]})
            w = 2'd3;
        else if (code inside {[10'd30:10'd36]})
            w = 2'd2;
        else if (code inside {[10'd16:10'd22]})
            w = 2'd1;
        return w;
    endfunction

    function automatic logic [14:0] note_pitch(input logic [9:0] code, input logic [3:0] octave);
        logic [7:0] n;
        n = 8'({octave, 3'b000}) + 8'({octave, 2'b00}) + 8'(note_offset(code));
        if (n >= 8'(PITCH_ROM_SIZE))
            n = 8'(PITCH_ROM_SIZE - 1);
        return PITCH_ROM[n[6:0]];
    endfunction

endpackage

@@ hdl/kva_ctrl_regs.sv @@
// Synth control settings: cutoff, filter flag, volume, octave and exit flag.
// Depends on kva_pkg.
module kva_ctrl_regs
    import kva_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          press_en,
    input  logic [9:0]    key_code,
    output kva_settings_t settings
);

    kva_settings_t set_reg;
    kva_settings_t set_next;

    always_comb
    begin
        set_next = set_reg;
        if (press_en)
        begin
            case (key_code)
                KEY_ESC:         set_next.exit_flag = 1'b1;
                KEY_CUTOFF_DOWN: set_next.cutoff = (set_reg.cutoff >= CUTOFF_STEP) ?
                                                   set_reg.cutoff - CUTOFF_STEP : 13'd0;
                KEY_CUTOFF_UP:   set_next.cutoff =
                                     (set_reg.cutoff + CUTOFF_STEP <= CUTOFF_MAX) ?
                                     set_reg.cutoff + CUTOFF_STEP : CUTOFF_MAX;
                KEY_VOL_DOWN:    if (set_reg.volume != 5'd0)
                                     set_next.volume = set_reg.volume - 5'd1;
                KEY_VOL_UP:      if (set_reg.volume < VOLUME_MAX)
                                     set_next.volume = set_reg.volume + 5'd1;
                KEY_FILTER:      set_next.filter = ~set_reg.filter;
                KEY_KP1:         set_next.octave = 4'd1;
                KEY_KP2:         set_next.octave = 4'd2;
                KEY_KP3:         set_next.octave = 4'd3;
                KEY_KP4:         set_next.octave = 4'd4;
                KEY_KP5:         set_next.octave = 4'd5;
                KEY_KP6:         set_next.octave = 4'd6;
                KEY_KP7:         set_next.octave = 4'd7;
                KEY_KP8:         set_next.octave = 4'd8;
                KEY_KP9:         set_next.octave = 4'd9;
                default:         set_next = set_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg.cutoff    <= CUTOFF_RESET;
            set_reg.filter    <= 1'b0;
            set_reg.volume    <= VOLUME_RESET;
            set_reg.octave    <= OCTAVE_RESET;
            set_reg.exit_flag <= 1'b0;
        end
        else
        begin
            set_reg <= set_next;
        end
    end

    assign settings = set_reg;

endmodule

@@ hdl/kva_voice_table.sv @@
// Voice table: key code and waveform per voice, one read port, one write port.
// Key code 0 marks a free voice. Depends on kva_pkg.
module kva_voice_table
    import kva_pkg::*;
#(
    parameter int VOICES = VOICES_DEFAULT,
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [9:0]       rd_key,
    output logic [1:0]       rd_wave,
    input  logic [IDX_W-1:0] wr_idx,
    input  kva_slot_wr_t     wr
);

    logic [9:0] key_reg  [VOICES];
    logic [1:0] wave_reg [VOICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                key_reg[i]  <= KEY_NONE;
                wave_reg[i] <= 2'd0;
            end
        end
        else if (wr.en)
        begin
            key_reg[wr_idx]  <= wr.key;
            wave_reg[wr_idx] <= wr.wave;
        end
    end

    assign rd_key  = key_reg[rd_idx];
    assign rd_wave = wave_reg[rd_idx];

endmodule

@@ hdl/keyboard_voice_allocator_unit.sv @@
// Top level of the keyboard voice allocator: command channel, scan sequencer,
// voice table and settings. Depends on kva_pkg, kva_voice_table, kva_ctrl_regs.
//
// Usage:
//   An event transfers in at a rising edge with start high and busy low. The
//   block then holds busy high until its result has been shown. Every event
//   gives exactly one result on rsp, marked by done for one cycle; the
//   receiver cannot stall, so done is never held.
//   Control key presses update the settings at the accept edge. Note presses
//   scan the voice table for the first free voice and releases scan for the
//   first voice holding the key; the scan uses one shared key comparator and
//   looks at one voice per cycle, stopping at the first hit.
//   For events that need no scan the sequencer goes from idle straight to the
//   done state; scanning events pass through the scan state first and stay
//   there until a hit or the last voice. busy stays high through the done
//   cycle, so the next event can transfer in at the end of the idle cycle that
//   follows it. A new event is thus taken only once the last one is through.
//   After escape the exit flag sticks and later events only report state.
//   Reset (rst_n low, asynchronous) frees all voices, restores cutoff 1000,
//   filter off, volume 10, octave 4, and returns the sequencer to idle.
module keyboard_voice_allocator_unit
    import kva_pkg::*;
#(
    parameter int VOICES = VOICES_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  kva_cmd_t cmd,
    output logic     done,
    output kva_rsp_t rsp
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    kva_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [9:0]       code_reg, code_next;      // key held by the event
    logic             press_reg, press_next;    // scan for a free voice vs. release
    logic [14:0]      pitch_reg, pitch_next;    // ROM pitch looked up at accept
    logic [1:0]       wave_reg, wave_next;
    kva_voice_t       voice_reg, voice_next;

    kva_settings_t settings;
    kva_slot_wr_t  slot_wr;
    logic [9:0]    rd_key;
    logic [1:0]    rd_wave;
    logic [9:0]    target;

    logic accept;
    logic act;
    logic press_note;
    logic release_key;
    logic match;

    // Event decode at the accept edge; exit flag is the value before this event
    assign accept      = start && !busy;
    assign act         = !settings.exit_flag && (cmd.event_kind == EV_KEY);
    assign press_note  = act && (cmd.req_type == REQ_PRESS) && is_note_key(cmd.key_code);
    assign release_key = act && (cmd.req_type == REQ_RELEASE) && (cmd.key_code != KEY_NONE);

    // Shared comparator: free slot on a press, matching slot on a release
    assign target = press_reg ? KEY_NONE : code_reg;
    assign match  = (rd_key == target);

    kva_voice_table #(
        .VOICES (VOICES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (idx_reg),
        .rd_key  (rd_key),
        .rd_wave (rd_wave),
        .wr_idx  (idx_reg),
        .wr      (slot_wr)
    );

    kva_ctrl_regs u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .press_en (accept && act && (cmd.req_type == REQ_PRESS)),
        .key_code (cmd.key_code),
        .settings (settings)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (press_note || release_key) ? ST_SCAN : ST_DONE;
            ST_SCAN:
                if (match || (idx_reg == LAST_IDX))
                    state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and table write control
    always_comb
    begin
        idx_next   = idx_reg;
        code_next  = code_reg;
        press_next = press_reg;
        pitch_next = pitch_reg;
        wave_next  = wave_reg;
        voice_next = voice_reg;
        slot_wr    = '0;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    idx_next   = '0;
                    code_next  = cmd.key_code;
                    press_next = press_note;
                    pitch_next = note_pitch(cmd.key_code, settings.octave);
                    wave_next  = note_wave(cmd.key_code);
                    voice_next = '0;
                end
            ST_SCAN:
                if (match)
                begin
                    slot_wr.en             = 1'b1;
                    slot_wr.key            = press_reg ? code_reg : KEY_NONE;
                    slot_wr.wave           = press_reg ? wave_reg : rd_wave;
                    voice_next.updated     = 1'b1;
                    voice_next.index       = 2'(idx_reg);
                    voice_next.pitch       = press_reg ? pitch_reg : 15'd0;
                    voice_next.on          = press_reg;
                    voice_next.waveform    = press_reg ? wave_reg : rd_wave;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            ST_DONE:
                idx_next = idx_reg;
            default:
                idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        press_reg <= press_next;
        pitch_reg <= pitch_next;
        wave_reg  <= wave_next;
        voice_reg <= voice_next;
    end

    // Outputs: settings are stable while busy, so they are read live
    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign rsp.voice_updated  = voice_reg.updated;
    assign rsp.voice_index    = voice_reg.index;
    assign rsp.voice_pitch    = voice_reg.pitch;
    assign rsp.voice_on       = voice_reg.on;
    assign rsp.voice_waveform = voice_reg.waveform;
    assign rsp.filter_cutoff  = settings.cutoff;
    assign rsp.filter_enabled = settings.filter;
    assign rsp.volume_steps   = settings.volume;
    assign rsp.octave_now     = settings.octave;
    assign rsp.exit_request   = settings.exit_flag;

endmodule
